/* rtl/core/noe_pkg.sv */
// Shared constants and a helper function for the neighbor occupancy efficiency block.
`default_nettype none
package noe_pkg;
   localparam int NEIGHBORS_DEF = 18;
   localparam int OCC_W = 24;
   localparam int TOL_W = 16;
   localparam logic [TOL_W-1:0] TOL_RESET = 16'd1228;
   localparam logic [OCC_W-1:0] ONE_Q16_8 = 24'd256;
   localparam logic [OCC_W-1:0] OCC_MAX = 24'hFFFFFF;

   // Wire b is similar to wire a when |b - a| * 4096 <= tol * a.
   function automatic logic within_tol(input logic [OCC_W-1:0] b,
                                       input logic [OCC_W-1:0] a,
                                       input logic [TOL_W-1:0] tol);
      logic [OCC_W-1:0] d;
      logic [OCC_W+TOL_W-1:0] lhs;
      logic [OCC_W+TOL_W-1:0] rhs;
      d = (b > a) ? (b - a) : (a - b);
      lhs = {{TOL_W-12{1'b0}}, d, 12'd0};
      rhs = tol * a;
      return lhs <= rhs;
   endfunction
endpackage
`default_nettype wire

/* rtl/core/noe_cell.sv */
// One cell of the wire row: stores a wire, counts similar wires, forwards its word.
`default_nettype none
module noe_cell #(
   parameter int CW = 5
) (
   input  wire logic                      clock,
   input  wire logic                      load_en,
   input  wire logic [noe_pkg::OCC_W-1:0] load_occ,
   input  wire logic                      load_pres,
   input  wire logic                      rot_en,
   input  wire logic                      clr_cnt,
   input  wire logic                      cnt_en,
   input  wire logic [noe_pkg::TOL_W-1:0] tol,
   input  wire logic [noe_pkg::OCC_W-1:0] prev_occ,
   input  wire logic                      prev_pres,
   output logic [noe_pkg::OCC_W-1:0]      occ_ff,
   output logic                           pres_ff,
   output logic [CW-1:0]                  cnt_ff
);
   // rotating word visits every cell; count its similarity against the stored one
   logic [noe_pkg::OCC_W-1:0] rot_occ_ff;
   logic                      rot_pres_ff;
   logic [noe_pkg::OCC_W-1:0] own_occ_ff;
   logic                      own_pres_ff;
   logic                      hit;

   assign occ_ff = rot_occ_ff;
   assign pres_ff = rot_pres_ff;
   assign hit = rot_pres_ff && own_pres_ff &&
                noe_pkg::within_tol(own_occ_ff, rot_occ_ff, tol);

   always_ff @(posedge clock) begin
      if (load_en) begin
         rot_occ_ff <= load_occ;
         rot_pres_ff <= load_pres;
         own_occ_ff <= load_occ;
         own_pres_ff <= load_pres;
      end else if (rot_en) begin
         rot_occ_ff <= prev_occ;
         rot_pres_ff <= prev_pres;
      end
      if (clr_cnt) begin
         cnt_ff <= '0;
      end else if (cnt_en && hit) begin
         cnt_ff <= cnt_ff + CW'(1);
      end
   end
endmodule
`default_nettype wire

/* rtl/core/noe_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module noe_div #(
   parameter int NW = 48,
   parameter int DW = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic               done,
   output logic [NW-1:0]      quo
);
   localparam int SW = $clog2(NW + 1);
   logic [NW-1:0] q_ff;
   logic [DW:0]   r_ff;
   logic [DW-1:0] d_ff;
   logic [SW-1:0] n_ff;
   logic          busy_ff;
   logic [DW:0]   trial;

   assign trial = {r_ff[DW-1:0], q_ff[NW-1]};
   assign quo = q_ff;
   assign done = busy_ff && (n_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         n_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         n_ff <= SW'(NW);
      end else if (busy_ff) begin
         if (n_ff == '0) begin
            busy_ff <= 1'b0;
         end else begin
            n_ff <= n_ff - SW'(1);
         end
      end
      if (start) begin
         q_ff <= num;
         r_ff <= '0;
         d_ff <= den;
      end else if (busy_ff && n_ff != '0) begin
         if (trial >= {1'b0, d_ff}) begin
            r_ff <= trial - {1'b0, d_ff};
            q_ff <= {q_ff[NW-2:0], 1'b1};
         end else begin
            r_ff <= trial;
            q_ff <= {q_ff[NW-2:0], 1'b0};
         end
      end
   end
endmodule
`default_nettype wire

/* rtl/core/neighbor_occupancy_efficiency.sv */
// Top level: loads neighbor wires, finds the reference wire, averages similar wires.
//
//  channel  direction  ports
//  req      in         req_valid req_stall req_occupancy req_wire_present
//                      req_test_occupancy req_last
//  rsp      out        rsp_valid rsp_stall rsp_efficiency rsp_average
//                      rsp_reference_wire rsp_no_similar
//  csr      in         csr_write csr_wdata (similarity_tolerance)
//
// Non-last words are taken back to back while loading. A last word starts the
// computation: rotation steps through the cell row, a max scan, the sum pass, and
// two serial divisions (average, then efficiency), each started by dstart and ended by done;
// the divisions are skipped when no wire is similar or the similar sum is zero. Reset is
// synchronous; the stored wires are not cleared. req_stall is high while a computation
// runs or a result waits; a held result waits on rsp_stall.
`default_nettype none
module neighbor_occupancy_efficiency #(
   parameter int NEIGHBORS = noe_pkg::NEIGHBORS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [noe_pkg::OCC_W-1:0] req_occupancy,
   input  wire logic                      req_wire_present,
   input  wire logic [noe_pkg::OCC_W-1:0] req_test_occupancy,
   input  wire logic                      req_last,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [noe_pkg::OCC_W-1:0]      rsp_efficiency,
   output logic [noe_pkg::OCC_W-1:0]      rsp_average,
   output logic [4:0]                     rsp_reference_wire,
   output logic                           rsp_no_similar,
   input  wire logic                      csr_write,
   input  wire logic [noe_pkg::TOL_W-1:0] csr_wdata
);
   localparam int IW = $clog2(NEIGHBORS + 1);
   localparam int XW = $clog2(NEIGHBORS);
   localparam int CW = $clog2(NEIGHBORS + 1);
   localparam int OW = noe_pkg::OCC_W;
   localparam int SW = OW + CW;
   localparam int ENW = OW + CW + 16;

   localparam logic [2:0] S_LOAD = 3'd0;
   localparam logic [2:0] S_ROT  = 3'd1;
   localparam logic [2:0] S_MAX  = 3'd2;
   localparam logic [2:0] S_SUM  = 3'd3;
   localparam logic [2:0] S_DIVA = 3'd4;
   localparam logic [2:0] S_DIVE = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   logic [2:0]              st_ff;
   logic [IW-1:0]           li_ff;
   logic [IW-1:0]           k_ff;
   logic [noe_pkg::TOL_W-1:0] tol_ff;
   logic [OW-1:0]           test_ff;
   logic [XW-1:0]           ref_ff;
   logic [CW-1:0]           best_ff;
   logic [CW-1:0]           h_ff;
   logic [SW-1:0]           sum_ff;
   logic [OW-1:0]           avg_ff;
   logic                    dstart_ff;

   logic                    acc;
   logic [OW-1:0]           ld_occ;
   logic [OW-1:0]           c_occ  [NEIGHBORS];
   logic                    c_pres [NEIGHBORS];
   logic [CW-1:0]           c_cnt  [NEIGHBORS];
   logic [OW-1:0]           s_occ  [NEIGHBORS];
   logic                    s_pres [NEIGHBORS];
   logic [OW-1:0]           ref_occ;
   logic [XW-1:0]           kx;

   assign acc = req_valid && !req_stall;
   assign req_stall = (st_ff != S_LOAD);
   assign ld_occ = (req_occupancy == '0) ? noe_pkg::ONE_Q16_8 : req_occupancy;
   assign kx = k_ff[XW-1:0];
   assign ref_occ = s_occ[ref_ff];

   // own copies of the wires for the sum pass
   always_ff @(posedge clock) begin
      if (acc && li_ff < IW'(NEIGHBORS)) begin
         s_occ[li_ff[XW-1:0]] <= ld_occ;
         s_pres[li_ff[XW-1:0]] <= req_wire_present;
      end
   end

   // N shifts bring every rotating word back home; offsets 1 .. N-1 are counted
   for (genvar g = 0; g < NEIGHBORS; g++) begin : g_cell
      noe_cell #(.CW(CW)) u_cell (
         .clock     (clock),
         .load_en   (acc && li_ff == IW'(g)),
         .load_occ  (ld_occ),
         .load_pres (req_wire_present),
         .rot_en    (st_ff == S_ROT && k_ff != IW'(NEIGHBORS)),
         .clr_cnt   (acc && req_last),
         .cnt_en    (st_ff == S_ROT && k_ff != '0 && k_ff != IW'(NEIGHBORS)),
         .tol       (tol_ff),
         .prev_occ  (c_occ[(g + NEIGHBORS - 1) % NEIGHBORS]),
         .prev_pres (c_pres[(g + NEIGHBORS - 1) % NEIGHBORS]),
         .occ_ff    (c_occ[g]),
         .pres_ff   (c_pres[g]),
         .cnt_ff    (c_cnt[g])
      );
   end

   // divider: avg = (2*sum + h) / (2h) ; eff = (2*w*h<<16 + sum) / (2*sum)
   localparam int NW = ENW + 2;
   localparam int DW = SW + 1;
   logic [NW-1:0] dnum;
   logic [DW-1:0] dden;
   logic          ddone;
   logic [NW-1:0] dquo;
   logic [OW+CW-1:0] wh;

   assign wh = test_ff * h_ff;
   always_comb begin
      if (st_ff == S_DIVA) begin
         dnum = NW'({sum_ff, 1'b0}) + NW'(h_ff);
         dden = DW'({h_ff, 1'b0});
      end else begin
         dnum = NW'({wh, 17'd0}) + NW'(sum_ff);
         dden = {sum_ff, 1'b0};
      end
   end

   noe_div #(.NW(NW), .DW(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (dstart_ff),
      .num   (dnum),
      .den   (dden),
      .done  (ddone),
      .quo   (dquo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_LOAD;
         li_ff <= '0;
         k_ff <= '0;
         tol_ff <= noe_pkg::TOL_RESET;
         rsp_valid <= 1'b0;
         dstart_ff <= 1'b0;
      end else begin
         dstart_ff <= 1'b0;
         if (csr_write) begin
            tol_ff <= csr_wdata;
         end
         unique case (st_ff)
            S_LOAD: begin
               if (acc) begin
                  if (li_ff < IW'(NEIGHBORS)) begin
                     li_ff <= li_ff + IW'(1);
                  end
                  if (req_last) begin
                     li_ff <= '0;
                     test_ff <= req_test_occupancy;
                     k_ff <= '0;
                     st_ff <= S_ROT;
                  end
               end
            end
            S_ROT: begin
               if (k_ff == IW'(NEIGHBORS)) begin
                  k_ff <= IW'(1);
                  ref_ff <= '0;
                  best_ff <= c_cnt[0];
                  st_ff <= S_MAX;
               end else begin
                  k_ff <= k_ff + IW'(1);
               end
            end
            S_MAX: begin
               if (k_ff == IW'(NEIGHBORS)) begin
                  k_ff <= '0;
                  h_ff <= '0;
                  sum_ff <= '0;
                  st_ff <= S_SUM;
               end else begin
                  if (c_cnt[kx] > best_ff) begin
                     best_ff <= c_cnt[kx];
                     ref_ff <= kx;
                  end
                  k_ff <= k_ff + IW'(1);
               end
            end
            S_SUM: begin
               if (k_ff == IW'(NEIGHBORS)) begin
                  if (h_ff == '0) begin
                     rsp_efficiency <= '0;
                     rsp_average <= '0;
                     rsp_reference_wire <= '0;
                     rsp_no_similar <= 1'b1;
                     rsp_valid <= 1'b1;
                     st_ff <= S_OUT;
                  end else if (sum_ff == '0) begin
                     rsp_efficiency <= (test_ff != '0) ? noe_pkg::OCC_MAX : '0;
                     rsp_average <= '0;
                     rsp_reference_wire <= 5'(ref_ff);
                     rsp_no_similar <= 1'b0;
                     rsp_valid <= 1'b1;
                     st_ff <= S_OUT;
                  end else begin
                     dstart_ff <= 1'b1;
                     st_ff <= S_DIVA;
                  end
               end else begin
                  if (s_pres[kx] && noe_pkg::within_tol(s_occ[kx], ref_occ, tol_ff)) begin
                     h_ff <= h_ff + CW'(1);
                     sum_ff <= sum_ff + SW'(s_occ[kx]);
                  end
                  k_ff <= k_ff + IW'(1);
               end
            end
            S_DIVA: begin
               if (ddone) begin
                  avg_ff <= (dquo > NW'(noe_pkg::OCC_MAX)) ? noe_pkg::OCC_MAX : dquo[OW-1:0];
                  dstart_ff <= 1'b1;
                  st_ff <= S_DIVE;
               end
            end
            S_DIVE: begin
               if (ddone) begin
                  rsp_efficiency <= (dquo > NW'(noe_pkg::OCC_MAX)) ?
                                    noe_pkg::OCC_MAX : dquo[OW-1:0];
                  rsp_average <= avg_ff;
                  rsp_reference_wire <= 5'(ref_ff);
                  rsp_no_similar <= 1'b0;
                  rsp_valid <= 1'b1;
                  st_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  rsp_valid <= 1'b0;
                  st_ff <= S_LOAD;
               end
            end
            default: st_ff <= S_LOAD;
         endcase
      end
   end

   a_valid_only_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> st_ff == S_OUT) else $error("rsp_valid outside output state");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      st_ff != S_LOAD |-> !acc) else $error("word accepted while busy");
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_similar |-> rsp_average == '0 && rsp_efficiency == '0)
      else $error("no_similar with nonzero results");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      li_ff <= IW'(NEIGHBORS)) else $error("load index out of range");
endmodule
`default_nettype wire
